>>> design/assert_macros.svh
// Assertion macros used by the checker file of the history ring.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the synchronous reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/thrs_pkg.sv
// Shared types and constants of the tagged history ring search block.
// No dependencies; imported by every module and interface of the block but thrs_ram.
package thrs_pkg;

    localparam int TAG_W   = 64;
    localparam int PAY_W   = 64;
    localparam int CNT_W   = 7;
    localparam int MAX_OUT = 64;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rec;
        logic walk;
        logic done;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic walk_end;
    } t_stat;

endpackage

>>> design/thrs_in_if.sv
// Input channel of the history ring: valid/ready plus one record or query item.
// Depends on thrs_pkg for the field widths.
interface thrs_in_if
    import thrs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [TAG_W-1:0]   tag_high;
    logic [TAG_W-1:0]   tag_low;
    logic [PAY_W-1:0]   payload_in;
    logic [CNT_W-1:0]   result_limit;

    modport source (
        output valid, action, tag_high, tag_low, payload_in, result_limit,
        input  ready
    );

    modport sink (
        input  valid, action, tag_high, tag_low, payload_in, result_limit,
        output ready
    );
endinterface

>>> design/thrs_out_if.sv
// Output channel of the history ring: valid/ready plus one result item.
// Depends on thrs_pkg for the field widths.
interface thrs_out_if
    import thrs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [PAY_W-1:0]   payload_out;
    logic [CNT_W-1:0]   found_total;
    logic               last;

    modport source (
        output valid, kind, payload_out, found_total, last,
        input  ready
    );

    modport sink (
        input  valid, kind, payload_out, found_total, last,
        output ready
    );
endinterface

>>> design/thrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module thrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data between reads
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/thrs_ctrl.sv
// Controller state machine of the history ring: sequences record and query items.
// Depends on thrs_pkg for the command and status structs.
module thrs_ctrl
    import thrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_action,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REC  = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.capture = accept;
        o_cmd.rec     = (r_state == ST_REC) && i_stat.out_free;
        o_cmd.walk    = (r_state == ST_WALK);
        o_cmd.done    = (r_state == ST_DONE) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = i_in_action ? ST_WALK : ST_REC;
                end
            end
            ST_REC: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (i_stat.walk_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

>>> design/thrs_dp.sv
// Datapath of the history ring: record RAM, head and fill count, search walk,
// one-deep pending match and the output register. Depends on thrs_pkg, thrs_ram.
module thrs_dp
    import thrs_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [TAG_W-1:0] i_tag_high,
    input  logic [TAG_W-1:0] i_tag_low,
    input  logic [PAY_W-1:0] i_payload_in,
    input  logic [CNT_W-1:0] i_result_limit,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_kind            o_kind,
    output logic [PAY_W-1:0] o_payload_out,
    output logic [CNT_W-1:0] o_found_total,
    output logic             o_last
);
    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int RW = 2 * TAG_W + PAYLOAD_BITS;

    // ring head and fill count
    logic [AW-1:0]           r_wp;
    logic [FW-1:0]           r_fill;

    // captured item
    logic [TAG_W-1:0]        r_q_high;
    logic [TAG_W-1:0]        r_q_low;
    logic [PAYLOAD_BITS-1:0] r_q_pay;
    logic [CNT_W-1:0]        r_limit;

    // walk state
    logic [AW-1:0]           r_rd_ptr;
    logic [FW-1:0]           r_issued;
    logic [FW-1:0]           r_total;
    logic [CNT_W-1:0]        r_found;
    logic                    r_dvalid;
    logic                    r_pend_v;
    logic [PAYLOAD_BITS-1:0] r_pend_pay;

    // output register
    logic                    r_out_v;
    t_kind                   r_out_kind;
    logic [PAY_W-1:0]        r_out_pay;
    logic [CNT_W-1:0]        r_out_found;
    logic                    r_out_last;

    logic [RW-1:0]           rdata;
    logic [TAG_W-1:0]        rd_high;
    logic [TAG_W-1:0]        rd_low;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic                    out_free;
    logic                    below_limit;
    logic                    match;
    logic                    take;
    logic                    push;
    logic                    rd_en;
    logic [AW-1:0]           wp_prev;
    logic [AW-1:0]           rd_prev;

    thrs_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rec),
        .i_waddr (r_wp),
        .i_wdata ({r_q_high, r_q_low, r_q_pay}),
        .i_re    (rd_en),
        .i_raddr (r_rd_ptr),
        .o_rdata (rdata)
    );

    assign rd_high = rdata[RW-1 -: TAG_W];
    assign rd_low  = rdata[PAYLOAD_BITS +: TAG_W];
    assign rd_pay  = rdata[PAYLOAD_BITS-1:0];

    assign out_free    = !r_out_v || i_out_ready;
    assign below_limit = (r_found < r_limit);
    assign match       = r_dvalid && (rd_high == r_q_high) && (rd_low == r_q_low);
    // consume the read word unless a match must push the pending one into a full output
    assign take  = i_cmd.walk && r_dvalid && below_limit && (!match || !r_pend_v || out_free);
    assign push  = take && match && r_pend_v;
    assign rd_en = i_cmd.walk && (r_issued < r_total) && below_limit && (!r_dvalid || take);

    assign wp_prev = (r_wp == '0) ? AW'(DEPTH - 1) : r_wp - 1'b1;
    assign rd_prev = (r_rd_ptr == '0) ? AW'(DEPTH - 1) : r_rd_ptr - 1'b1;

    always_comb begin
        o_stat.out_free = out_free;
        o_stat.walk_end = !below_limit || ((r_issued == r_total) && !r_dvalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.rec) begin
            r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_fill != FW'(DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q_high <= i_tag_high;
            r_q_low  <= i_tag_low;
            r_q_pay  <= i_payload_in[PAYLOAD_BITS-1:0];
            r_limit  <= (i_result_limit > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT)
                                                           : i_result_limit;
        end
    end

    // walk from the newest slot towards the oldest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
            r_pend_v <= 1'b0;
            r_found  <= '0;
            r_issued <= '0;
            r_total  <= '0;
            r_rd_ptr <= '0;
        end else if (i_cmd.capture) begin
            r_dvalid <= 1'b0;
            r_pend_v <= 1'b0;
            r_found  <= '0;
            r_issued <= '0;
            r_total  <= r_fill;
            r_rd_ptr <= wp_prev;
        end else begin
            if (rd_en) begin
                r_dvalid <= 1'b1;
                r_issued <= r_issued + 1'b1;
                r_rd_ptr <= rd_prev;
            end else if (take) begin
                r_dvalid <= 1'b0;
            end
            if (take && match) begin
                r_pend_v <= 1'b1;
                r_found  <= r_found + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && match) begin
            r_pend_pay <= rd_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.rec || push || i_cmd.done) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.rec) begin
            r_out_kind  <= KIND_ACK;
            r_out_pay   <= '0;
            r_out_found <= '0;
            r_out_last  <= 1'b1;
        end else if (push) begin
            r_out_kind  <= KIND_MATCH;
            r_out_pay   <= PAY_W'(r_pend_pay);
            r_out_found <= '0;
            r_out_last  <= 1'b0;
        end else if (i_cmd.done) begin
            // the held match closes the query; with none held, report nothing found
            r_out_kind  <= r_pend_v ? KIND_MATCH : KIND_NONE;
            r_out_pay   <= r_pend_v ? PAY_W'(r_pend_pay) : '0;
            r_out_found <= r_found;
            r_out_last  <= 1'b1;
        end else begin
            r_out_kind  <= r_out_kind;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_kind        = r_out_kind;
    assign o_payload_out = r_out_pay;
    assign o_found_total = r_out_found;
    assign o_last        = r_out_last;
endmodule

>>> design/tagged_history_ring_search.sv
// Tagged history ring search: keeps the last DEPTH records (128-bit tag plus
// payload) and searches them by tag.
// Channels: i_in takes record (action 0) and query (action 1) items; o_out
// gives results. A transfer happens when valid and ready are both high.
// A record writes the slot at the head and gives one acknowledgement; both
// happen in the record state once the output register is free, and the
// controller then returns to idle for the next item.
// A query reads the stored records newest first, one RAM read per cycle
// while the output is not stalled, and stops at the fill count or when
// result_limit (clamped to 64) matches are found. Each match is held in a
// pending register and moves to the output register when the next one is
// found; the last match carries found_total and last. With no match one
// "nothing found" result is given. The last result is written from the done
// state once the output register is free; the controller then returns to idle.
// One item is in work at a time; i_in.ready is high only between items.
// A result waiting in the output register does not block the next transfer
// on i_in; a stalled receiver holds the walk when a further result is due.
// Reset (synchronous, active low) empties the ring and drops any result.
// Depends on thrs_pkg, thrs_in_if, thrs_out_if, thrs_ctrl, thrs_dp, thrs_ram.
module tagged_history_ring_search
    import thrs_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thrs_in_if.sink     i_in,
    thrs_out_if.source  o_out
);
    t_cmd  cmd;
    t_stat stat;
    t_kind kind;
    logic  in_ready;

    thrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (in_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    thrs_dp #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_tag_high     (i_in.tag_high),
        .i_tag_low      (i_in.tag_low),
        .i_payload_in   (i_in.payload_in),
        .i_result_limit (i_in.result_limit),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_kind         (kind),
        .o_payload_out  (o_out.payload_out),
        .o_found_total  (o_out.found_total),
        .o_last         (o_out.last)
    );

    assign i_in.ready = in_ready;
    assign o_out.kind = kind;
endmodule

>>> design/thrs_checker.sv
// Port-level assertions for the tagged history ring search, bound to the top.
// Depends on thrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module thrs_checker
    import thrs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_out_kind,
    input logic [PAY_W-1:0] i_out_payload,
    input logic [CNT_W-1:0] i_out_found,
    input logic             i_out_last
);
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) && $stable(i_out_payload) && $stable(i_out_found) && $stable(i_out_last), "stalled result changed")
    `ASSERT_CLK(a_ack_form, i_clk, i_rst_n, i_out_valid && (i_out_kind == KIND_ACK) |-> i_out_last && (i_out_found == '0) && (i_out_payload == '0), "malformed acknowledgement")
    `ASSERT_CLK(a_match_count, i_clk, i_rst_n, i_out_valid && (i_out_kind == KIND_MATCH) |-> (i_out_last ? (i_out_found != '0) : (i_out_found == '0)), "match count on wrong result")
    `ASSERT_CLK(a_busy_after_take, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready, "second item taken while busy")
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !i_out_valid, "result survived reset")
endmodule

bind tagged_history_ring_search thrs_checker u_thrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.kind),
    .i_out_payload (o_out.payload_out),
    .i_out_found   (o_out.found_total),
    .i_out_last    (o_out.last)
);

>>> tb/sv/tagged_history_ring_search_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the tagged history ring search block: directed table, then
// random record/query traffic, with results checked against an in-bench ring model.
// Depends on thrs_pkg, thrs_in_if, thrs_out_if and tagged_history_ring_search.
module tagged_history_ring_search_tb;
    import thrs_pkg::*;

    localparam int DEPTH          = 64;
    localparam int PAYLOAD_BITS   = 64;
    localparam int POOL_SIZE      = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;

    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    localparam logic [TAG_W-1:0] ZERO64 = '0;
    localparam logic [TAG_W-1:0] ONES64 = '1;
    localparam logic [TAG_W-1:0] ALT_A  = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [TAG_W-1:0] ALT_5  = 64'h5555_5555_5555_5555;
    localparam logic [CNT_W-1:0] LIM_ZERO = 7'd0;
    localparam logic [CNT_W-1:0] LIM_MAX  = 7'd64;
    localparam logic [CNT_W-1:0] LIM_TOP  = 7'd127;

    localparam logic [PAY_W-1:0] PAY_MASK =
        (PAYLOAD_BITS >= PAY_W) ? '1 : ((PAY_W'(1) << PAYLOAD_BITS) - 1);

    typedef struct packed {
        logic             action;
        logic [TAG_W-1:0] tag_high;
        logic [TAG_W-1:0] tag_low;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] limit;
    } t_item;

    typedef struct packed {
        t_kind            kind;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] total;
        logic             last;
    } t_result;

    // typed = 1: the expected single result is the one given in the row
    typedef struct packed {
        t_item item;
        logic  typed;
        t_kind exp_kind;
    } t_row;

    localparam int N_DIRECTED = 18;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{'{ACT_QUERY,  ZERO64, ZERO64, ZERO64, LIM_MAX},  1'b1, KIND_NONE},
        '{'{ACT_RECORD, ONES64, ONES64, ONES64, LIM_ZERO}, 1'b1, KIND_ACK},
        '{'{ACT_RECORD, ZERO64, ZERO64, ZERO64, LIM_TOP},  1'b1, KIND_ACK},
        '{'{ACT_RECORD, ONES64, ONES64, ALT_5,  LIM_ZERO}, 1'b1, KIND_ACK},
        '{'{ACT_QUERY,  ONES64, ONES64, ONES64, LIM_TOP},  1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ONES64, ONES64, ZERO64, LIM_ZERO}, 1'b1, KIND_NONE},
        '{'{ACT_QUERY,  ONES64, ONES64, ZERO64, 7'd1},     1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ZERO64, ZERO64, ZERO64, LIM_MAX},  1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ONES64, ZERO64, ZERO64, LIM_MAX},  1'b1, KIND_NONE},
        '{'{ACT_QUERY,  ZERO64, ONES64, ZERO64, LIM_MAX},  1'b1, KIND_NONE},
        '{'{ACT_RECORD, ZERO64, ONES64, ALT_A,  LIM_ZERO}, 1'b1, KIND_ACK},
        '{'{ACT_RECORD, ALT_5,  ALT_A,  ONES64, LIM_MAX},  1'b1, KIND_ACK},
        '{'{ACT_QUERY,  ZERO64, ONES64, ZERO64, 7'd65},    1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ONES64, ONES64, ZERO64, 7'd2},     1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ALT_5,  ALT_A,  ZERO64, 7'd63},    1'b0, KIND_ACK},
        '{'{ACT_RECORD, ONES64, ONES64, 64'd1,  LIM_ZERO}, 1'b1, KIND_ACK},
        '{'{ACT_QUERY,  ONES64, ONES64, ZERO64, LIM_MAX},  1'b0, KIND_ACK},
        '{'{ACT_QUERY,  ALT_A,  ALT_5,  ZERO64, LIM_MAX},  1'b1, KIND_NONE}
    };

    logic i_clk;
    logic i_rst_n;

    thrs_in_if  in_if ();
    thrs_out_if out_if ();

    tagged_history_ring_search #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ring model state
    logic [TAG_W-1:0] ring_tag_high [DEPTH];
    logic [TAG_W-1:0] ring_tag_low  [DEPTH];
    logic [PAY_W-1:0] ring_payload  [DEPTH];
    int unsigned      ring_wr_pos;
    int unsigned      ring_fill;

    t_result step_results [$];
    t_result pending_results [$];
    t_result want_result;

    logic [TAG_W-1:0] pool_high [POOL_SIZE];
    logic [TAG_W-1:0] pool_low  [POOL_SIZE];

    int src_idle_pct;
    int sink_idle_pct;
    int stall_cycles;
    int failures;
    int records_seen;
    int queries_seen;
    int matches_out;
    int deepest_query;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Apply one item to the ring model; the results land in step_results.
    function automatic void ring_step(input t_item it);
        int unsigned lim;
        int unsigned slot;
        int unsigned hits;
        t_result     tail;
        step_results.delete();
        if (it.action == ACT_RECORD) begin
            ring_tag_high[ring_wr_pos] = it.tag_high;
            ring_tag_low[ring_wr_pos]  = it.tag_low;
            ring_payload[ring_wr_pos]  = it.payload & PAY_MASK;
            ring_wr_pos = (ring_wr_pos + 1) % DEPTH;
            if (ring_fill < DEPTH) ring_fill++;
            step_results.push_back('{KIND_ACK, '0, '0, 1'b1});
            records_seen++;
            return;
        end
        queries_seen++;
        lim  = (it.limit > MAX_OUT) ? MAX_OUT : it.limit;
        hits = 0;
        // newest first, stop at the fill count or the clamped limit
        for (int i = 0; i < ring_fill && hits < lim; i++) begin
            slot = (ring_wr_pos + DEPTH - 1 - i) % DEPTH;
            if (ring_tag_high[slot] == it.tag_high && ring_tag_low[slot] == it.tag_low) begin
                step_results.push_back('{KIND_MATCH, ring_payload[slot], '0, 1'b0});
                hits++;
            end
        end
        if (hits == 0) begin
            step_results.push_back('{KIND_NONE, '0, '0, 1'b1});
        end else begin
            tail       = step_results.pop_back();
            tail.total = CNT_W'(hits);
            tail.last  = 1'b1;
            step_results.push_back(tail);
        end
        if (hits > deepest_query) deepest_query = hits;
    endfunction

    // Mostly tags from a small pool so queries find hits; one pool tag dominates.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        int    roll;
        it.action = ($urandom_range(99) < 55) ? ACT_RECORD : ACT_QUERY;
        if ($urandom_range(99) < 12) begin
            it.tag_high = {$urandom, $urandom};
            it.tag_low  = {$urandom, $urandom};
        end else begin
            pick        = ($urandom_range(99) < 55) ? 0 : $urandom_range(POOL_SIZE - 1, 1);
            it.tag_high = pool_high[pick];
            it.tag_low  = pool_low[pick];
        end
        it.payload = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 8) begin
            it.limit = LIM_ZERO;
        end else if (roll < 25) begin
            it.limit = CNT_W'($urandom_range(127, MAX_OUT + 1));
        end else begin
            it.limit = CNT_W'($urandom_range(MAX_OUT, 1));
        end
        return it;
    endfunction

    task automatic log_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS) $display("ERROR: %s", what);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic drive_item(input t_item it, input logic typed, input t_kind fixed_kind);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.action       <= it.action;
        in_if.tag_high     <= it.tag_high;
        in_if.tag_low      <= it.tag_low;
        in_if.payload_in   <= it.payload;
        in_if.result_limit <= it.limit;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
            @(negedge i_clk);
        end
        ring_step(it);
        if (typed) begin
            pending_results.push_back('{fixed_kind, '0, '0, 1'b1});
        end else begin
            foreach (step_results[k]) pending_results.push_back(step_results[k]);
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                log_failure($sformatf("result with none expected: kind %0d payload %h total %0d last %0d",
                    out_if.kind, out_if.payload_out, out_if.found_total, out_if.last));
            end else begin
                want_result = pending_results.pop_front();
                if (out_if.kind !== want_result.kind
                        || out_if.payload_out !== want_result.payload
                        || out_if.found_total !== want_result.total
                        || out_if.last !== want_result.last) begin
                    log_failure($sformatf({"result mismatch: expected kind %0d payload %h ",
                        "total %0d last %0d, got kind %0d payload %h total %0d last %0d"},
                        want_result.kind, want_result.payload, want_result.total,
                        want_result.last, out_if.kind, out_if.payload_out,
                        out_if.found_total, out_if.last));
                end
                if (want_result.kind == KIND_MATCH) matches_out++;
            end
        end
    end

    // Count cycles without any transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        in_if.valid        = 1'b0;
        in_if.action       = ACT_RECORD;
        in_if.tag_high     = '0;
        in_if.tag_low      = '0;
        in_if.payload_in   = '0;
        in_if.result_limit = '0;
        out_if.ready       = 1'b0;
        i_rst_n            = 1'b0;
        src_idle_pct       = 26;
        sink_idle_pct      = 56;
        stall_cycles       = 0;
        failures           = 0;
        records_seen       = 0;
        queries_seen       = 0;
        matches_out        = 0;
        deepest_query      = 0;
        ring_wr_pos        = 0;
        ring_fill          = 0;
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_high[p] = {$urandom, $urandom};
            pool_low[p]  = {$urandom, $urandom};
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIRECTED[r]) drive_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].exp_kind);

        for (int n = 0; n < 38; n++) drive_item(random_item(), 1'b0, KIND_ACK);

        src_idle_pct  = 56;
        sink_idle_pct = 26;
        for (int n = 0; n < 37; n++) drive_item(random_item(), 1'b0, KIND_ACK);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (int n = 0; n < 37; n++) drive_item(random_item(), 1'b0, KIND_ACK);
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end

        $display("Ran %0d records and %0d queries; %0d matching results, deepest query %0d hits.",
            records_seen, queries_seen, matches_out, deepest_query);
        $display("Pacing: sender/receiver stalls, swapped, then back-to-back; %0d failures.",
            failures);
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
